/* rtl/core/fsr_pkg.sv */
`timescale 1ns / 1ps
package fsr_pkg;

	localparam int MAX_COLS_DEF  = 512;
	localparam int MAX_ROWS_DEF  = 512;
	localparam int TRIG_FRAC_DEF = 14;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN      = 2'd3;

	localparam logic [9:0]         FRAME_WIDTH_RST  = 10'd512;
	localparam logic [9:0]         FRAME_HEIGHT_RST = 10'd512;
	localparam logic signed [15:0] ROT_COS_RST      = 16'sd16384;
	localparam logic signed [15:0] ROT_SIN_RST      = 16'sd0;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef struct packed {
		logic       op;
		logic [8:0] col;
		logic [8:0] row;
		logic [7:0] in_blue;
		logic [7:0] in_green;
		logic [7:0] in_red;
	} in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       inside_res;
	} out_t;

	// frame store word: blue in the low byte
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [9:0]         frame_width;
		logic [9:0]         frame_height;
		logic signed [15:0] rot_cos;
		logic signed [15:0] rot_sin;
	} cfg_t;

	// mapper result handed to the memory stage
	typedef struct packed {
		logic valid;
		logic fetch;
		logic in_frame;
		logic wr_ok;
		logic origin;
	} map_ctl_t;

endpackage

/* rtl/core/fsr_ram.sv */
`timescale 1ns / 1ps
module fsr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/core/fsr_mapper.sv */
`timescale 1ns / 1ps
module fsr_mapper #(
	parameter int MAX_COLS       = fsr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS       = fsr_pkg::MAX_ROWS_DEF,
	parameter int TRIG_FRAC_BITS = fsr_pkg::TRIG_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  fsr_pkg::in_t                in_item,
	input  fsr_pkg::cfg_t               cfg,
	output logic                        up_ready,
	input  logic                        down_ready,
	output fsr_pkg::map_ctl_t           ctl,
	output logic [$clog2(MAX_COLS)-1:0] x_sel,
	output logic [$clog2(MAX_ROWS)-1:0] y_sel,
	output fsr_pkg::pix_t               pix
);

	localparam int CW  = $clog2(MAX_COLS + 1);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int XAW = $clog2(MAX_COLS);
	localparam int YAW = $clog2(MAX_ROWS);
	localparam int NXW = ((CW > 10) ? CW : 10) + 1;
	localparam int NYW = ((RW > 10) ? RW : 10) + 1;
	localparam int NW  = (NXW > NYW) ? NXW : NYW;
	localparam int PW  = 16 + NW;
	localparam int SW  = PW + 1;
	localparam int TW  = SW - TRIG_FRAC_BITS;
	localparam int DW  = (CW > RW) ? CW : RW;
	localparam int SXW = ((TW > DW) ? TW : DW) + 2;
	localparam logic signed [SW-1:0] BIAS = SW'((1 << TRIG_FRAC_BITS) - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic r1, r2, r3, r4;

	assign r4 = !v_s4 || down_ready;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign up_ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
		end
	end

	// stage 1: clamp frame size, centre, offsets
	logic [CW-1:0]         w_c;
	logic [RW-1:0]         h_c;
	logic [CW-1:0]         cx_c;
	logic [RW-1:0]         cy_c;
	logic signed [NXW-1:0] nx_c;
	logic signed [NYW-1:0] ny_c;

	always_comb begin
		if (cfg.frame_width == 10'd0) begin
			w_c = CW'(1);
		end else if (32'(cfg.frame_width) > 32'(MAX_COLS)) begin
			w_c = CW'(MAX_COLS);
		end else begin
			w_c = CW'(cfg.frame_width);
		end
		if (cfg.frame_height == 10'd0) begin
			h_c = RW'(1);
		end else if (32'(cfg.frame_height) > 32'(MAX_ROWS)) begin
			h_c = RW'(MAX_ROWS);
		end else begin
			h_c = RW'(cfg.frame_height);
		end
		cx_c = w_c >> 1;
		cy_c = h_c >> 1;
		nx_c = NXW'($signed({1'b0, in_item.col})) - NXW'($signed({1'b0, cx_c}));
		ny_c = NYW'($signed({1'b0, in_item.row})) - NYW'($signed({1'b0, cy_c}));
	end

	logic                  op_s1, op_s2, op_s3;
	logic [8:0]            col_s1, col_s2, col_s3;
	logic [8:0]            row_s1, row_s2, row_s3;
	fsr_pkg::pix_t         pix_s1, pix_s2, pix_s3, pix_s4;
	logic [CW-1:0]         w_s1, w_s2, w_s3;
	logic [RW-1:0]         h_s1, h_s2, h_s3;
	logic [CW-1:0]         cx_s1, cx_s2, cx_s3;
	logic [RW-1:0]         cy_s1, cy_s2, cy_s3;
	logic signed [NXW-1:0] nx_s1;
	logic signed [NYW-1:0] ny_s1;
	logic signed [15:0]    c_s1, s_s1;
	logic signed [PW-1:0]  pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic signed [SW-1:0]  a_s3, b_s3;
	fsr_pkg::map_ctl_t     ctl_s4;
	logic [XAW-1:0]        x_s4;
	logic [YAW-1:0]        y_s4;

	always_ff @(posedge clk) begin
		if (r1) begin
			op_s1  <= in_item.op;
			col_s1 <= in_item.col;
			row_s1 <= in_item.row;
			pix_s1 <= '{red: in_item.in_red, green: in_item.in_green, blue: in_item.in_blue};
			w_s1   <= w_c;
			h_s1   <= h_c;
			cx_s1  <= cx_c;
			cy_s1  <= cy_c;
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
			c_s1   <= cfg.rot_cos;
			s_s1   <= cfg.rot_sin;
		end
	end

	// stage 2: four products
	always_ff @(posedge clk) begin
		if (r2) begin
			op_s2  <= op_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			pix_s2 <= pix_s1;
			w_s2   <= w_s1;
			h_s2   <= h_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			pcx_s2 <= c_s1 * nx_s1;
			psy_s2 <= s_s1 * ny_s1;
			psx_s2 <= s_s1 * nx_s1;
			pcy_s2 <= c_s1 * ny_s1;
		end
	end

	// stage 3: inverse rotation sums
	always_ff @(posedge clk) begin
		if (r3) begin
			op_s3  <= op_s2;
			col_s3 <= col_s2;
			row_s3 <= row_s2;
			pix_s3 <= pix_s2;
			w_s3   <= w_s2;
			h_s3   <= h_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			a_s3   <= SW'(pcx_s2) + SW'(psy_s2);
			b_s3   <= SW'(pcy_s2) - SW'(psx_s2);
		end
	end

	// stage 4: truncate toward zero, re-centre, bounds check
	logic signed [SW-1:0]  a_adj, b_adj;
	logic signed [TW-1:0]  ta, tb;
	logic signed [SXW-1:0] sx, sy;
	logic                  inside_c;

	always_comb begin
		a_adj = a_s3[SW-1] ? a_s3 + BIAS : a_s3;
		b_adj = b_s3[SW-1] ? b_s3 + BIAS : b_s3;
		ta = TW'(a_adj >>> TRIG_FRAC_BITS);
		tb = TW'(b_adj >>> TRIG_FRAC_BITS);
		sx = SXW'(ta) + SXW'($signed({1'b0, cx_s3}));
		sy = SXW'(tb) + SXW'($signed({1'b0, cy_s3}));
		inside_c = !sx[SXW-1] && !sy[SXW-1]
			&& (sx < SXW'($signed({1'b0, w_s3})))
			&& (sy < SXW'($signed({1'b0, h_s3})));
	end

	always_ff @(posedge clk) begin
		if (r4) begin
			ctl_s4.valid    <= v_s3;
			ctl_s4.fetch    <= (op_s3 == fsr_pkg::OP_FETCH);
			ctl_s4.in_frame <= inside_c;
			ctl_s4.wr_ok    <= (32'(col_s3) < 32'(MAX_COLS)) && (32'(row_s3) < 32'(MAX_ROWS));
			ctl_s4.origin   <= (col_s3 == 9'd0) && (row_s3 == 9'd0);
			x_s4   <= (op_s3 == fsr_pkg::OP_FETCH) ? sx[XAW-1:0] : XAW'(col_s3);
			y_s4   <= (op_s3 == fsr_pkg::OP_FETCH) ? sy[YAW-1:0] : YAW'(row_s3);
			pix_s4 <= pix_s3;
		end
	end

	always_comb begin
		ctl       = ctl_s4;
		ctl.valid = v_s4;
	end
	assign x_sel = x_s4;
	assign y_sel = y_s4;
	assign pix   = pix_s4;

endmodule

/* rtl/core/frame_rotate_sampler.sv */
// A store gives no result; a fetch passes the mapper, memory stage and output register.
// Throughput: one transaction per cycle, stores and fetches mixed, while in_stall is low.
// Each item touches the single frame memory port once, in order, in the memory stage.
// Reset: config registers go to 512, 512, 16384, 0 and the pipeline empties;
// frame memory contents stay undefined until written (no clearing pass).
`timescale 1ns / 1ps
module frame_rotate_sampler #(
	parameter int MAX_COLS       = fsr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS       = fsr_pkg::MAX_ROWS_DEF,
	parameter int TRIG_FRAC_BITS = fsr_pkg::TRIG_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  fsr_pkg::in_t                     in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output fsr_pkg::out_t                    out_item,
	input  logic                             cfg_we,
	input  logic [fsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int XAW   = $clog2(MAX_COLS);
	localparam int YAW   = $clog2(MAX_ROWS);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	fsr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= fsr_pkg::FRAME_WIDTH_RST;
			cfg_q.frame_height <= fsr_pkg::FRAME_HEIGHT_RST;
			cfg_q.rot_cos      <= fsr_pkg::ROT_COS_RST;
			cfg_q.rot_sin      <= fsr_pkg::ROT_SIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fsr_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[9:0];
				fsr_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[9:0];
				fsr_pkg::CFG_ROT_COS:      cfg_q.rot_cos      <= $signed(cfg_data);
				fsr_pkg::CFG_ROT_SIN:      cfg_q.rot_sin      <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	fsr_pkg::map_ctl_t ctl4;
	logic [XAW-1:0]    x4;
	logic [YAW-1:0]    y4;
	fsr_pkg::pix_t     pix4;
	logic              up_ready;
	logic              r5, r_out;

	fsr_mapper #(
		.MAX_COLS      (MAX_COLS),
		.MAX_ROWS      (MAX_ROWS),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_mapper (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.up_ready  (up_ready),
		.down_ready(r5),
		.ctl       (ctl4),
		.x_sel     (x4),
		.y_sel     (y4),
		.pix       (pix4)
	);

	assign in_stall = !up_ready;

	// stage 5: linear address, then the memory access
	logic          v_s5, fetch_s5, inside_s5, wr_s5, origin_s5;
	logic [AW-1:0] addr_s5;
	fsr_pkg::pix_t pix_s5;
	logic          v_s6, inside_s6;
	fsr_pkg::pix_t fill_s6, fill_q, rdata;
	logic          ram_we, ram_re;

	assign r_out = !v_s6 || !out_stall;
	// a store never waits on the output side
	assign r5    = !v_s5 || !fetch_s5 || r_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (r5)    v_s5 <= ctl4.valid;
			if (r_out) v_s6 <= v_s5 && fetch_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (r5) begin
			fetch_s5  <= ctl4.fetch;
			inside_s5 <= ctl4.in_frame;
			wr_s5     <= ctl4.wr_ok;
			origin_s5 <= ctl4.origin;
			addr_s5   <= AW'(y4) * AW'(MAX_COLS) + AW'(x4);
			pix_s5    <= pix4;
		end
		if (r_out) begin
			inside_s6 <= inside_s5;
			fill_s6   <= fill_q;
		end
		// copy of entry (0,0) for the fill colour
		if (ram_we && origin_s5) begin
			fill_q <= pix_s5;
		end
	end

	assign ram_we = v_s5 && !fetch_s5 && wr_s5;
	assign ram_re = v_s5 && fetch_s5 && r_out;

	fsr_ram #(
		.WIDTH($bits(fsr_pkg::pix_t)),
		.DEPTH(DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (addr_s5),
		.wdata(pix_s5),
		.rdata(rdata)
	);

	fsr_pkg::pix_t pix_out;

	assign pix_out              = inside_s6 ? rdata : fill_s6;
	assign out_valid            = v_s6;
	assign out_item.out_blue    = pix_out.blue;
	assign out_item.out_green   = pix_out.green;
	assign out_item.out_red     = pix_out.red;
	assign out_item.inside_res  = inside_s6;

`ifndef SYNTHESIS
	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("frame memory written and read in one cycle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s5 && fetch_s5))
		else $error("result without a fetch in the memory stage");

	a_fetch_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && fetch_s5 && !r_out) |=> (v_s5 && fetch_s5 && $stable(addr_s5)))
		else $error("stalled fetch lost in the memory stage");

	a_store_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !fetch_s5) |-> r5)
		else $error("store blocked in the memory stage");
`endif

endmodule
